>>> design/csol_pkg.sv
// ----------------------------------------------------------------------------
// csol_pkg
// shared types, field widths and codes of the column span occlusion list
// ----------------------------------------------------------------------------
package csol_pkg;

   localparam int MAX_RANGES  = 32;
   localparam int RESULT_CAP  = 32;
   localparam int FIELD_W     = 10;
   localparam int COL_W       = 12;
   localparam int IDX_W       = $clog2(MAX_RANGES);
   localparam int CNT_W       = $clog2(MAX_RANGES + 1);
   localparam int RCNT_W      = $clog2(RESULT_CAP + 1);

   localparam logic [FIELD_W-1:0] RESET_WIDTH = 10'd320;

   localparam logic [1:0] ACT_CLIP  = 2'd0;
   localparam logic [1:0] ACT_QUERY = 2'd1;
   localparam logic [1:0] ACT_FRAME = 2'd2;

   localparam logic [1:0] KIND_FRAG  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   typedef logic signed [COL_W-1:0] col_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [FIELD_W-1:0] first_col;
      logic [FIELD_W-1:0] last_col;
      logic               solid;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [FIELD_W-1:0] frag_first;
      logic [FIELD_W-1:0] frag_last;
      logic               maybe_visible;
      logic               last_of_run;
      logic               overflow;
   } rsp_type;

endpackage

>>> design/column_span_occlusion_list.sv
// ----------------------------------------------------------------------------
// column_span_occlusion_list
// sorted list of covered screen column ranges with clip, query and frame start
// ----------------------------------------------------------------------------
// usage:
//   req channel (valid/ready) takes one transaction: clip a span, query a span
//   or start a new frame. rsp channel (valid/ready) returns the results of a
//   transaction in order; last_of_run marks the final one. a clip that is
//   fully covered returns no result at all.
//   csr_wr_en / csr_wr_data set the viewport width; it is applied at the next
//   frame start.
//   req_ready is high only while the sequencer is idle. the sequencer walks
//   the list through a single compare/select datapath that reads one list
//   entry per cycle while the result side does not hold it; a clip that runs
//   past its entry emits each fragment found and commits, and a solid one then
//   removes each swallowed entry.
//   results leave through an output register behind a one-deep holding
//   register; when rsp_ready is low the sequencer waits only when it has a
//   new result or its last result to release and both registers are full.
//   synchronous reset restores the sentinels -2..-1 and 320..321, the width
//   of 320, and drops any pending result.
// ----------------------------------------------------------------------------
module column_span_occlusion_list (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  csol_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output csol_pkg::rsp_type rsp_payload,
   input  logic              csr_wr_en,
   input  logic [9:0]        csr_wr_data
);
   import csol_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_FRONT  = 3'd2;
   localparam logic [2:0] ST_MERGE  = 3'd3;
   localparam logic [2:0] ST_COMMIT = 3'd4;
   localparam logic [2:0] ST_REMOVE = 3'd5;
   localparam logic [2:0] ST_QSCAN  = 3'd6;
   localparam logic [2:0] ST_FLUSH  = 3'd7;

   localparam logic [2:0] AOP_HOLD   = 3'd0;
   localparam logic [2:0] AOP_INIT   = 3'd1;
   localparam logic [2:0] AOP_INSERT = 3'd2;
   localparam logic [2:0] AOP_REMOVE = 3'd3;
   localparam logic [2:0] AOP_START  = 3'd4;
   localparam logic [2:0] AOP_END    = 3'd5;

   localparam col_type ONE_COL   = col_type'(1);
   localparam col_type LEFT_S    = col_type'(-2);
   localparam col_type LEFT_E    = col_type'(-1);

   // range list
   col_type start_ff [MAX_RANGES];
   col_type end_ff   [MAX_RANGES];
   col_type start_in [MAX_RANGES];
   col_type end_in   [MAX_RANGES];
   col_type up_s     [MAX_RANGES];
   col_type up_e     [MAX_RANGES];
   col_type dn_s     [MAX_RANGES];
   col_type dn_e     [MAX_RANGES];

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic [IDX_W-1:0]   s_ff, s_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [RCNT_W-1:0]  cnt_ff, cnt_in;
   col_type            f_ff, f_in;
   col_type            l_ff, l_in;
   logic               solid_ff, solid_in;
   col_type            cur_end_ff, cur_end_in;
   col_type            maxcol_ff, maxcol_in;
   logic [FIELD_W-1:0] width_ff, width_in;
   rsp_type            pend_ff, pend_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_payload_ff, rsp_payload_in;

   logic [2:0]         arr_op;
   logic [FIELD_W-1:0] init_width;
   col_type            rd_s, rd_e;
   col_type            req_f, req_l, req_lc;
   logic               req_empty;
   logic               list_full;
   logic               out_free, cap_ok, hold;
   logic               emit_req, out_flush, out_push;
   rsp_type            emit_data, out_data;

   assign rd_s      = start_ff[ptr_ff[IDX_W-1:0]];
   assign rd_e      = end_ff[ptr_ff[IDX_W-1:0]];
   assign req_f     = col_type'({{(COL_W-FIELD_W){1'b0}}, req_payload.first_col});
   assign req_l     = col_type'({{(COL_W-FIELD_W){1'b0}}, req_payload.last_col});
   assign req_empty = (req_f > req_l) || (req_f > maxcol_ff);
   assign req_lc    = (req_l > maxcol_ff) ? maxcol_ff : req_l;
   assign list_full = (count_ff == CNT_W'(MAX_RANGES));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cap_ok    = (cnt_ff < RCNT_W'(RESULT_CAP));
   assign hold      = cap_ok && pend_valid_ff && !out_free;
   assign init_width = reset ? RESET_WIDTH : width_ff;

   // neighbor taps for one-step shifts
   for (genvar g = 0; g < MAX_RANGES; g++) begin : g_tap
      if (g == 0) begin : g_lo
         assign up_s[g] = start_ff[g];
         assign up_e[g] = end_ff[g];
      end else begin : g_mid
         assign up_s[g] = start_ff[g-1];
         assign up_e[g] = end_ff[g-1];
      end
      if (g == MAX_RANGES - 1) begin : g_hi
         assign dn_s[g] = start_ff[g];
         assign dn_e[g] = end_ff[g];
      end else begin : g_nx
         assign dn_s[g] = start_ff[g+1];
         assign dn_e[g] = end_ff[g+1];
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_RANGES; i++) begin
         start_in[i] = start_ff[i];
         end_in[i]   = end_ff[i];
         unique case (arr_op)
            AOP_HOLD: begin
            end
            AOP_INIT: begin
               if (i == 0) begin
                  start_in[i] = LEFT_S;
                  end_in[i]   = LEFT_E;
               end else if (i == 1) begin
                  start_in[i] = col_type'({{(COL_W-FIELD_W){1'b0}}, init_width});
                  end_in[i]   = col_type'({{(COL_W-FIELD_W){1'b0}}, init_width}) + ONE_COL;
               end
            end
            AOP_INSERT: begin
               if (IDX_W'(i) == s_ff) begin
                  start_in[i] = f_ff;
                  end_in[i]   = l_ff;
               end else if (IDX_W'(i) > s_ff) begin
                  start_in[i] = up_s[i];
                  end_in[i]   = up_e[i];
               end
            end
            AOP_REMOVE: begin
               if (IDX_W'(i) > s_ff) begin
                  start_in[i] = dn_s[i];
                  end_in[i]   = dn_e[i];
               end
            end
            AOP_START: begin
               if (IDX_W'(i) == s_ff) begin
                  start_in[i] = f_ff;
               end
            end
            AOP_END: begin
               if (IDX_W'(i) == s_ff) begin
                  end_in[i] = l_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      s_in       = s_ff;
      rem_in     = rem_ff;
      count_in   = count_ff;
      f_in       = f_ff;
      l_in       = l_ff;
      solid_in   = solid_ff;
      cur_end_in = cur_end_ff;
      maxcol_in  = maxcol_ff;
      width_in   = csr_wr_en ? csr_wr_data : width_ff;
      arr_op     = AOP_HOLD;
      emit_req   = 1'b0;
      emit_data  = '0;
      out_flush  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               f_in     = req_f;
               l_in     = req_lc;
               solid_in = req_payload.solid;
               ptr_in   = '0;
               state_in = ST_FLUSH;
               unique case (req_payload.action)
                  ACT_CLIP: begin
                     if (req_empty) begin
                        emit_req       = 1'b1;
                        emit_data.kind = KIND_EMPTY;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  ACT_QUERY: begin
                     if (req_empty) begin
                        emit_req       = 1'b1;
                        emit_data.kind = KIND_DONE;
                     end else begin
                        state_in = ST_QSCAN;
                     end
                  end
                  ACT_FRAME: begin
                     arr_op         = AOP_INIT;
                     count_in       = CNT_W'(2);
                     maxcol_in      = col_type'({{(COL_W-FIELD_W){1'b0}}, width_ff}) - ONE_COL;
                     emit_req       = 1'b1;
                     emit_data.kind = KIND_DONE;
                  end
                  default: begin
                     emit_req       = 1'b1;
                     emit_data.kind = KIND_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if ((ptr_ff < count_ff - CNT_W'(1)) && (rd_e < f_ff - ONE_COL)) begin
               ptr_in = ptr_ff + CNT_W'(1);
            end else begin
               s_in     = ptr_ff[IDX_W-1:0];
               state_in = ST_FRONT;
            end
         end
         ST_FRONT: begin
            cur_end_in = rd_e;
            ptr_in     = ptr_ff + CNT_W'(1);
            state_in   = (l_ff <= rd_e) ? ST_FLUSH : ST_MERGE;
            if (f_ff < rd_s) begin
               emit_req             = 1'b1;
               emit_data.kind       = KIND_FRAG;
               emit_data.frag_first = f_ff[FIELD_W-1:0];
               if (l_ff < rd_s - ONE_COL) begin
                  emit_data.frag_last = l_ff[FIELD_W-1:0];
                  emit_data.overflow  = solid_ff && list_full;
                  state_in            = ST_FLUSH;
                  if (solid_ff && !list_full) begin
                     arr_op   = AOP_INSERT;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  emit_data.frag_last = FIELD_W'(rd_s - ONE_COL);
                  if (solid_ff) begin
                     arr_op = AOP_START;
                  end
               end
            end
         end
         ST_MERGE: begin
            emit_req             = 1'b1;
            emit_data.kind       = KIND_FRAG;
            emit_data.frag_first = FIELD_W'(cur_end_ff + ONE_COL);
            if (!hold) begin
               if ((ptr_ff < count_ff) && (l_ff >= rd_s - ONE_COL)) begin
                  emit_data.frag_last = FIELD_W'(rd_s - ONE_COL);
                  if (l_ff <= rd_e) begin
                     l_in     = rd_e;
                     rem_in   = ptr_ff - CNT_W'(s_ff);
                     state_in = ST_COMMIT;
                  end else begin
                     cur_end_in = rd_e;
                     ptr_in     = ptr_ff + CNT_W'(1);
                  end
               end else begin
                  emit_data.frag_last = l_ff[FIELD_W-1:0];
                  rem_in   = ptr_ff - CNT_W'(1) - CNT_W'(s_ff);
                  state_in = ST_COMMIT;
               end
            end else begin
               emit_data.frag_last = l_ff[FIELD_W-1:0];
            end
         end
         ST_COMMIT: begin
            state_in = ST_FLUSH;
            if (solid_ff) begin
               arr_op = AOP_END;
               if (rem_ff != '0) begin
                  state_in = ST_REMOVE;
               end
            end
         end
         ST_REMOVE: begin
            arr_op   = AOP_REMOVE;
            count_in = count_ff - CNT_W'(1);
            rem_in   = rem_ff - CNT_W'(1);
            if (rem_ff == CNT_W'(1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_QSCAN: begin
            if ((ptr_ff < count_ff - CNT_W'(1)) && (rd_e < l_ff)) begin
               ptr_in = ptr_ff + CNT_W'(1);
            end else begin
               emit_req                = 1'b1;
               emit_data.kind          = KIND_DONE;
               emit_data.maybe_visible = !((f_ff >= rd_s) && (l_ff <= rd_e));
               state_in                = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               out_flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (reset) begin
         arr_op = AOP_INIT;
      end
   end

   // holding register and output register
   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      cnt_in        = cnt_ff;
      out_push      = 1'b0;
      out_data      = pend_ff;
      if (emit_req && !hold && cap_ok) begin
         pend_in       = emit_data;
         pend_valid_in = 1'b1;
         cnt_in        = cnt_ff + RCNT_W'(1);
         out_push      = pend_valid_ff;
      end
      if (out_flush) begin
         cnt_in = '0;
         if (pend_valid_ff) begin
            out_push             = 1'b1;
            out_data.last_of_run = 1'b1;
            pend_valid_in        = 1'b0;
         end
      end
      rsp_valid_in   = out_push || (rsp_valid_ff && !rsp_ready);
      rsp_payload_in = out_push ? out_data : rsp_payload_ff;
   end

   always_ff @(posedge clock) begin
      start_ff       <= start_in;
      end_ff         <= end_in;
      ptr_ff         <= ptr_in;
      s_ff           <= s_in;
      rem_ff         <= rem_in;
      f_ff           <= f_in;
      l_ff           <= l_in;
      solid_ff       <= solid_in;
      cur_end_ff     <= cur_end_in;
      pend_ff        <= pend_in;
      rsp_payload_ff <= rsp_payload_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= CNT_W'(2);
         cnt_ff        <= '0;
         maxcol_ff     <= col_type'({{(COL_W-FIELD_W){1'b0}}, RESET_WIDTH}) - ONE_COL;
         width_ff      <= RESET_WIDTH;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cnt_ff        <= cnt_in;
         maxcol_ff     <= maxcol_in;
         width_ff      <= width_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // checks
   a_idle_nothing_held: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !pend_valid_ff)
      else $error("result still held while accepting a new transaction");

   a_frame_restores_count: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_payload.action == ACT_FRAME) |=> count_ff == CNT_W'(2))
      else $error("frame start did not restore the two sentinels");

   a_remove_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REMOVE) |-> (rem_ff != '0) && (count_ff > rem_ff))
      else $error("entry removal past the list");

   a_left_sentinel: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> start_ff[0] == LEFT_S)
      else $error("left sentinel start lost");

endmodule

>>> test/tb_column_span_occlusion_list.sv
// ----------------------------------------------------------------------------
// tb_column_span_occlusion_list
// self-checking bench for the column span occlusion list. a behavioral copy
// of the covered-range list predicts every fragment, query answer and frame
// acknowledge of each accepted transaction. results are checked field by
// field in order. directed spans, width extremes, a full list, a long result
// stall and random phases at several viewport widths are run in turn.
// ----------------------------------------------------------------------------
module tb_column_span_occlusion_list;
   timeunit 1ns;
   timeprecision 1ps;

   import csol_pkg::*;

   localparam logic [1:0] ACT_SPARE     = 2'd3;
   localparam int         SETTLE_CYCLES = 100;
   localparam int         LONG_HOLD     = 400;
   localparam int         CYCLE_LIMIT   = 2000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic    csr_wr_en = 1'b0;
   logic [9:0] csr_wr_data = '0;

   // predicted list state
   int      cov_first [MAX_RANGES];
   int      cov_last [MAX_RANGES];
   int      cov_count;
   int      frame_width;
   rsp_type item_results[$];
   rsp_type fragments_due[$];
   int      mismatches = 0;

   // stimulus control
   int      width_setting = 320;
   logic    steady = 1'b0;
   logic    hold_req = 1'b0;
   logic    hold_ack = 1'b0;
   int      cycles = 0;

   column_span_occlusion_list dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void restart_frame();
      cov_first[0] = -2;
      cov_last[0]  = -1;
      cov_first[1] = frame_width;
      cov_last[1]  = frame_width + 1;
      cov_count    = 2;
   endfunction

   function automatic void add_result(logic [1:0] k, int a, int b, logic vis, logic ovf);
      rsp_type r;
      if (item_results.size() >= RESULT_CAP) return;
      r.kind          = k;
      r.frag_first    = a[FIELD_W-1:0];
      r.frag_last     = b[FIELD_W-1:0];
      r.maybe_visible = vis;
      r.last_of_run   = 1'b0;
      r.overflow      = ovf;
      item_results.push_back(r);
   endfunction

   function automatic void predict_clip(int f, int l, logic solid);
      int   maxcol;
      int   s;
      int   n;
      int   i;
      int   removed;
      logic crunched;
      logic ovf;
      maxcol   = cov_last[cov_count-1] - 2;
      s        = 0;
      crunched = 1'b0;
      ovf      = 1'b0;
      if (f > l || f > maxcol) begin
         add_result(KIND_EMPTY, 0, 0, 1'b0, 1'b0);
         return;
      end
      if (l > maxcol) l = maxcol;
      while (s < cov_count - 1 && cov_last[s] < f - 1) s++;
      if (f < cov_first[s]) begin
         if (l < cov_first[s] - 1) begin
            if (solid) begin
               if (cov_count < MAX_RANGES) begin
                  for (i = cov_count; i > s; i--) begin
                     cov_first[i] = cov_first[i-1];
                     cov_last[i]  = cov_last[i-1];
                  end
                  cov_first[s] = f;
                  cov_last[s]  = l;
                  cov_count++;
               end else begin
                  ovf = 1'b1;
               end
            end
            add_result(KIND_FRAG, f, l, 1'b0, ovf);
            return;
         end
         add_result(KIND_FRAG, f, cov_first[s] - 1, 1'b0, 1'b0);
         if (solid) cov_first[s] = f;
      end
      if (l <= cov_last[s]) return;
      n = s;
      while (n + 1 < cov_count && l >= cov_first[n+1] - 1) begin
         add_result(KIND_FRAG, cov_last[n] + 1, cov_first[n+1] - 1, 1'b0, 1'b0);
         n++;
         if (l <= cov_last[n]) begin
            l = cov_last[n];
            crunched = 1'b1;
            break;
         end
      end
      if (!crunched) add_result(KIND_FRAG, cov_last[n] + 1, l, 1'b0, 1'b0);
      if (solid) begin
         cov_last[s] = l;
         if (n != s) begin
            removed = n - s;
            for (i = n + 1; i < cov_count; i++) begin
               cov_first[i-removed] = cov_first[i];
               cov_last[i-removed]  = cov_last[i];
            end
            cov_count -= removed;
         end
      end
   endfunction

   function automatic logic span_uncovered(int f, int l);
      int maxcol;
      int s;
      maxcol = cov_last[cov_count-1] - 2;
      s = 0;
      if (f > l || f > maxcol) return 1'b0;
      if (l > maxcol) l = maxcol;
      while (s < cov_count - 1 && cov_last[s] < l) s++;
      return !(f >= cov_first[s] && l <= cov_last[s]);
   endfunction

   function automatic void predict_item(req_type item);
      item_results.delete();
      case (item.action)
         ACT_CLIP: begin
            predict_clip(int'(item.first_col), int'(item.last_col), item.solid);
         end
         ACT_QUERY: begin
            add_result(KIND_DONE, 0, 0,
                       span_uncovered(int'(item.first_col), int'(item.last_col)), 1'b0);
         end
         ACT_FRAME: begin
            restart_frame();
            add_result(KIND_DONE, 0, 0, 1'b0, 1'b0);
         end
         default: begin
            add_result(KIND_DONE, 0, 0, 1'b0, 1'b0);
         end
      endcase
      if (item_results.size() > 0) item_results[item_results.size()-1].last_of_run = 1'b1;
      foreach (item_results[i]) fragments_due.push_back(item_results[i]);
   endfunction

   function automatic void check_field(string what, int want, int got);
      if (want != got) begin
         $display("%0t mismatch %s expected %0d actual %0d", $time, what, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_result(rsp_type got);
      rsp_type want;
      if (fragments_due.size() == 0) begin
         $display("%0t unexpected transaction expected none actual kind %0d cols %0d..%0d",
                  $time, got.kind, got.frag_first, got.frag_last);
         mismatches++;
         return;
      end
      want = fragments_due.pop_front();
      check_field("kind", int'(want.kind), int'(got.kind));
      check_field("frag_first", int'(want.frag_first), int'(got.frag_first));
      check_field("frag_last", int'(want.frag_last), int'(got.frag_last));
      check_field("maybe_visible", int'(want.maybe_visible), int'(got.maybe_visible));
      check_field("last_of_run", int'(want.last_of_run), int'(got.last_of_run));
      check_field("overflow", int'(want.overflow), int'(got.overflow));
   endfunction

   // prediction and checking, sampled at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         frame_width = int'(RESET_WIDTH);
         restart_frame();
         fragments_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_payload);
         if (req_valid && req_ready) predict_item(req_payload);
         if (csr_wr_en) frame_width = int'(csr_wr_data);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // result side ready with random stalls and a long hold-off on request
   initial begin
      int stall_left;
      forever begin
         @(negedge clock);
         if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            rsp_ready <= 1'b0;
            stall_left = LONG_HOLD;
            while (stall_left > 0) begin
               @(negedge clock);
               stall_left--;
            end
         end else if (steady || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            repeat (pick_gap()) @(negedge clock);
         end
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_item(logic [1:0] act, int f, int l, logic solid);
      int      gap;
      req_type item;
      gap = steady ? 0 : pick_gap();
      item.action    = act;
      item.first_col = f[FIELD_W-1:0];
      item.last_col  = l[FIELD_W-1:0];
      item.solid     = solid;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (fragments_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(int w);
      width_setting = w;
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w[9:0];
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_random_item();
      int r;
      int f;
      int l;
      int span;
      r = $urandom_range(0, 99);
      f = $urandom_range(0, width_setting - 1);
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, width_setting)
                                         : $urandom_range(0, 12);
      l = f + span;
      if (l > 1023) l = 1023;
      if (r < 4) begin
         send_item(ACT_FRAME, $urandom_range(0, 1023), $urandom_range(0, 1023),
                   1'($urandom_range(0, 1)));
      end else if (r < 6) begin
         send_item(ACT_SPARE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                   1'($urandom_range(0, 1)));
      end else if (r < 10) begin
         send_item(2'($urandom_range(0, 1)), $urandom_range(0, 1023),
                   $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
      end else if (r < 30) begin
         send_item(ACT_QUERY, f, l, 1'($urandom_range(0, 1)));
      end else begin
         send_item(ACT_CLIP, f, l, $urandom_range(0, 3) != 0);
      end
   endtask

   task automatic test_directed();
      send_item(ACT_QUERY, 0, 319, 1'b1);
      send_item(ACT_CLIP, 0, 1023, 1'b0);
      send_item(ACT_CLIP, 10, 20, 1'b1);
      send_item(ACT_CLIP, 30, 40, 1'b1);
      send_item(ACT_CLIP, 0, 50, 1'b0);
      send_item(ACT_QUERY, 12, 18, 1'b0);
      send_item(ACT_QUERY, 10, 25, 1'b0);
      send_item(ACT_CLIP, 12, 15, 1'b1);
      send_item(ACT_CLIP, 21, 29, 1'b1);
      send_item(ACT_CLIP, 5, 45, 1'b1);
      send_item(ACT_CLIP, 50, 40, 1'b1);
      send_item(ACT_CLIP, 400, 1023, 1'b1);
      send_item(ACT_QUERY, 50, 40, 1'b0);
      send_item(ACT_QUERY, 1023, 1023, 1'b0);
      send_item(ACT_CLIP, 319, 319, 1'b1);
      send_item(ACT_CLIP, 0, 0, 1'b1);
      send_item(ACT_CLIP, 0, 1023, 1'b0);
      send_item(ACT_SPARE, 1023, 1023, 1'b1);
      send_item(ACT_QUERY, 0, 1023, 1'b0);
      send_item(ACT_FRAME, 1023, 0, 1'b1);
      send_item(ACT_CLIP, 0, 1023, 1'b1);
      send_item(ACT_QUERY, 0, 1023, 1'b0);
      send_item(ACT_FRAME, 0, 0, 1'b0);
      settle();
   endtask

   task automatic test_width(int w);
      csr_write(w);
      // new width only applies from the next frame start
      send_item(ACT_CLIP, 0, 1023, 1'b0);
      send_item(ACT_FRAME, 0, 0, 1'b0);
      send_item(ACT_CLIP, 0, 1023, 1'b0);
      send_item(ACT_CLIP, w - 1, 1023, 1'b1);
      send_item(ACT_QUERY, 0, 1023, 1'b0);
      send_item(ACT_CLIP, 0, 0, 1'b1);
      send_item(ACT_QUERY, 0, 0, 1'b0);
      send_item(ACT_CLIP, 0, 1023, 1'b0);
      settle();
   endtask

   task automatic test_full_list();
      csr_write(320);
      send_item(ACT_FRAME, 0, 0, 1'b0);
      for (int k = 0; k < MAX_RANGES - 2; k++) send_item(ACT_CLIP, 2*k + 1, 2*k + 1, 1'b1);
      send_item(ACT_CLIP, 100, 110, 1'b1);
      send_item(ACT_QUERY, 100, 110, 1'b0);
      send_item(ACT_CLIP, 0, 1023, 1'b0);
      send_item(ACT_CLIP, 2, 2, 1'b1);
      send_item(ACT_CLIP, 200, 200, 1'b1);
      send_item(ACT_CLIP, 210, 210, 1'b1);
      send_item(ACT_CLIP, 0, 1023, 1'b1);
      send_item(ACT_QUERY, 0, 1023, 1'b0);
      send_item(ACT_FRAME, 0, 0, 1'b0);
      settle();
   endtask

   task automatic test_result_stall();
      hold_req = ~hold_req;
      repeat (10) send_random_item();
      settle();
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: csr_write(320);
            1: csr_write($urandom_range(1, 1023));
            2: csr_write($urandom_range(16, 64));
            default: csr_write(1023);
         endcase
         steady = (phase == 3);
         send_item(ACT_FRAME, 0, 0, 1'b0);
         repeat (3) send_random_item();
         settle();
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);
      test_directed();
      test_width(1);
      test_width(1023);
      test_width($urandom_range(2, 1022));
      test_full_list();
      test_result_stall();
      test_random();
      settle();
      if (mismatches == 0 && fragments_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/csol_pkg.sv
design/column_span_occlusion_list.sv
test/tb_column_span_occlusion_list.sv
